### sv/pre_pkg.sv
package pre_pkg;

   // deepest run buffer, and so the largest effective minimum
   localparam int MAX_MIN_LENGTH = 64;
   localparam int CNT_W          = $clog2(MAX_MIN_LENGTH + 1);
   localparam int ADDR_W         = $clog2(MAX_MIN_LENGTH);
   localparam int MIN_LEN_W      = 7;
   localparam int BYTE_W         = 8;

   localparam logic [BYTE_W-1:0] NEWLINE_CHAR = 8'd10;

   // csr register indexes
   localparam logic CSR_MIN_LENGTH    = 1'b0;
   localparam logic CSR_ALLOW_SPECIAL = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FL_READ,
      ST_FL_DATA,
      ST_NEWLINE
   } state_type;

   typedef struct packed {
      logic [CNT_W-1:0] min_eff;
      logic             allow_special;
   } cfg_type;

   // minimum saturated at the buffer depth
   function automatic logic [CNT_W-1:0] eff_min(input logic [MIN_LEN_W-1:0] m);
      int unsigned mv;
      mv = int'(m);
      if (mv > MAX_MIN_LENGTH) mv = MAX_MIN_LENGTH;
      return CNT_W'(mv);
   endfunction

   function automatic logic qualifies(input logic [BYTE_W-1:0] b, input logic special);
      logic q;
      if (special) begin
         q = (b >= 8'h20) && (b <= 8'h7e);
      end else begin
         q = ((b >= 8'h30) && (b <= 8'h39)) || ((b >= 8'h41) && (b <= 8'h5a)) ||
             ((b >= 8'h61) && (b <= 8'h7a));
      end
      return q;
   endfunction

endpackage

### sv/pre_ram.sv
module pre_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/pre_ctrl.sv
module pre_ctrl import pre_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [BYTE_W-1:0] req_tdata,
   input  logic              req_tlast,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [BYTE_W-1:0] rsp_tdata,
   output logic              rsp_tlast,
   output logic              mem_we,
   output logic [ADDR_W-1:0] mem_waddr,
   output logic [BYTE_W-1:0] mem_wdata,
   output logic              mem_re,
   output logic [ADDR_W-1:0] mem_raddr,
   input  logic [BYTE_W-1:0] mem_rdata
);

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              passing_ff, passing_in;
   logic [ADDR_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0]  flush_len_ff, flush_len_in;
   logic              nl_pend_ff, nl_pend_in;
   logic              out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0] out_data_ff, out_data_in;
   logic              out_last_ff, out_last_in;

   logic              out_free;
   logic              accept;
   logic              qual;
   logic              last_byte;
   logic [CNT_W-1:0]  count_inc;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         passing_ff   <= 1'b0;
         idx_ff       <= '0;
         flush_len_ff <= '0;
         nl_pend_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         passing_ff   <= passing_in;
         idx_ff       <= idx_in;
         flush_len_ff <= flush_len_in;
         nl_pend_ff   <= nl_pend_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff <= out_data_in;
      out_last_ff <= out_last_in;
   end

   assign out_free  = !out_valid_ff || rsp_tready;
   assign qual      = !req_tlast && qualifies(req_tdata, cfg.allow_special);
   assign last_byte = (CNT_W'(idx_ff) + CNT_W'(1)) == flush_len_ff;
   assign count_inc = (count_ff < CNT_W'(MAX_MIN_LENGTH)) ? count_ff + CNT_W'(1) : count_ff;
   assign accept    = req_tvalid && req_tready;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      passing_in   = passing_ff;
      idx_in       = idx_ff;
      flush_len_in = flush_len_ff;
      nl_pend_in   = nl_pend_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_data_in  = out_data_ff;
      out_last_in  = out_last_ff;
      req_tready   = 1'b0;
      mem_we       = 1'b0;
      mem_waddr    = count_ff[ADDR_W-1:0];
      mem_wdata    = req_tdata;
      mem_re       = 1'b0;
      mem_raddr    = idx_ff;

      unique case (state_ff)
         ST_IDLE: begin
            req_tready = out_free;
            if (req_tvalid && out_free) begin
               if (qual) begin
                  count_in = count_inc;
                  if (passing_ff) begin
                     out_valid_in = 1'b1;
                     out_data_in  = req_tdata;
                     out_last_in  = 1'b1;
                  end else begin
                     mem_we = count_ff < CNT_W'(MAX_MIN_LENGTH);
                     if (count_inc >= cfg.min_eff) begin
                        passing_in   = 1'b1;
                        flush_len_in = count_inc;
                        nl_pend_in   = 1'b0;
                        idx_in       = '0;
                        state_in     = ST_FL_READ;
                     end
                  end
               end else begin
                  count_in   = '0;
                  passing_in = 1'b0;
                  if (passing_ff || (count_ff >= cfg.min_eff)) begin
                     if (!passing_ff && (count_ff != '0)) begin
                        flush_len_in = count_ff;
                        nl_pend_in   = 1'b1;
                        idx_in       = '0;
                        state_in     = ST_FL_READ;
                     end else begin
                        out_valid_in = 1'b1;
                        out_data_in  = NEWLINE_CHAR;
                        out_last_in  = 1'b1;
                     end
                  end
               end
            end
         end
         ST_FL_READ: begin
            mem_re   = 1'b1;
            state_in = ST_FL_DATA;
         end
         ST_FL_DATA: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_data_in  = mem_rdata;
               out_last_in  = last_byte && !nl_pend_ff;
               if (!last_byte) begin
                  mem_re    = 1'b1;
                  mem_raddr = idx_ff + ADDR_W'(1);
                  idx_in    = idx_ff + ADDR_W'(1);
               end else begin
                  state_in = nl_pend_ff ? ST_NEWLINE : ST_IDLE;
               end
            end
         end
         ST_NEWLINE: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_data_in  = NEWLINE_CHAR;
               out_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;

   a_accept_room: assert property (@(posedge clock) disable iff (reset)
      accept |-> (!out_valid_ff || rsp_tready))
      else $error("input taken while result register is blocked");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_MIN_LENGTH))
      else $error("run count beyond buffer depth");

   a_passing_count: assert property (@(posedge clock) disable iff (reset)
      passing_ff |-> (count_ff != '0))
      else $error("passing with empty run");

   a_flush_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FL_DATA) |-> (CNT_W'(idx_ff) < flush_len_ff))
      else $error("flush index past run length");

   a_flush_start: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FL_READ) |=> (state_ff == ST_FL_DATA))
      else $error("flush read not followed by data state");

endmodule

### sv/printable_run_extractor.sv
// a pass-through byte or a lone newline is registered and appears in the cycle after its input transaction
// a buffer flush passes through ST_FL_READ and ST_FL_DATA, then moves one byte per cycle while the output is free
// throughput: one byte per cycle while passing and the response register is free; no input is taken
// during a flush, which reads the run buffer through its single read port and may end in a trailing newline
// reset: synchronous, active high; min_length 10, allow_special 0, run closed
// the run buffer is not cleared, only entries below the run count are ever read
module printable_run_extractor import pre_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   // request stream
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [7:0]           req_tdata,   // [7:0] in_byte
   input  logic                 req_tlast,   // stream_end
   // response stream
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [7:0]           rsp_tdata,   // [7:0] out_byte
   output logic                 rsp_tlast,   // last_of_burst
   // register write port
   input  logic                 csr_we,
   input  logic                 csr_addr,
   input  logic [MIN_LEN_W-1:0] csr_wdata
);

   // configuration registers
   logic [MIN_LEN_W-1:0] min_length_ff;
   logic                 allow_special_ff;
   cfg_type              cfg;

   // run buffer port
   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic [BYTE_W-1:0] mem_wdata;
   logic              mem_re;
   logic [ADDR_W-1:0] mem_raddr;
   logic [BYTE_W-1:0] mem_rdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_length_ff    <= MIN_LEN_W'(10);
         allow_special_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_MIN_LENGTH:    min_length_ff    <= csr_wdata;
            CSR_ALLOW_SPECIAL: allow_special_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // minimum saturates at the buffer depth
   assign cfg.min_eff       = eff_min(min_length_ff);
   assign cfg.allow_special = allow_special_ff;

   // holds the bytes of a run until it reaches the minimum
   pre_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (MAX_MIN_LENGTH)
   ) u_run_buffer (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   // run tracking, flush sequencing and the response register
   pre_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .mem_we     (mem_we),
      .mem_waddr  (mem_waddr),
      .mem_wdata  (mem_wdata),
      .mem_re     (mem_re),
      .mem_raddr  (mem_raddr),
      .mem_rdata  (mem_rdata)
   );

endmodule
